// ===== rtl/cdoy_pkg.sv =====
package cdoy_pkg;

  // One input item.
  typedef struct packed {
    logic        operation;
    logic [13:0] year;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [8:0]  year_day_in;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       valid_res;
    logic [8:0] year_day_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc_quot;
    logic calc_leap;
    logic check;
    logic step;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic out_free;
  } status_t;

  // Operation codes.
  localparam logic OpToYearDay  = 1'b0;
  localparam logic OpToMonthDay = 1'b1;

  // Division of a 14-bit year by 25 as a multiply by a scaled reciprocal.
  localparam logic [15:0] QuotMul   = 16'd41944;
  localparam int          QuotShift = 20;
  localparam logic [9:0]  Divisor25 = 10'd25;

  localparam logic [3:0] MonthFirst = 4'd1;
  localparam logic [3:0] MonthLast  = 4'd12;
  localparam logic [3:0] WalkLast   = 4'd11;
  localparam logic [4:0] DaysFeb     = 5'd28;
  localparam logic [4:0] DaysFebLeap = 5'd29;
  localparam logic [4:0] DaysShort   = 5'd30;
  localparam logic [4:0] DaysLong    = 5'd31;
  localparam logic [8:0] YearLen     = 9'd365;
  localparam logic [8:0] YearLenLeap = 9'd366;

  // Length of month m0 (0 = January) in a common or a leap year.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m0);
    logic [4:0] len;
    case (m0)
      4'd1: begin
        len = leap ? DaysFebLeap : DaysFeb;
      end
      4'd3, 4'd5, 4'd8, 4'd10: begin
        len = DaysShort;
      end
      default: begin
        len = DaysLong;
      end
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/cdoy_ctrl.sv =====
module cdoy_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cdoy_pkg::status_t status_i,
  output cdoy_pkg::cmd_t    cmd_o
);
  import cdoy_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_QUOT = 6'b000010,
    S_LEAP = 6'b000100,
    S_CHK  = 6'b001000,
    S_WALK = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_QUOT;
        end
      end
      S_QUOT: begin
        cmd_o.calc_quot = 1'b1;
        state_d         = S_LEAP;
      end
      S_LEAP: begin
        cmd_o.calc_leap = 1'b1;
        state_d         = S_CHK;
      end
      S_CHK: begin
        cmd_o.check = 1'b1;
        state_d     = S_WALK;
      end
      S_WALK: begin
        if (status_i.walk_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result loaded while the output register is still held");

  a_step_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !status_i.walk_done)
    else $error("walk stepped past its end");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_QUOT))
    else $error("accepted beat did not start a conversion");

endmodule

// ===== rtl/cdoy_dp.sv =====
module cdoy_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdoy_pkg::item_t   in_item_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output cdoy_pkg::res_t    out_item_o,
  input  cdoy_pkg::cmd_t    cmd_i,
  output cdoy_pkg::status_t status_o
);
  import cdoy_pkg::*;

  item_t      item_q;
  logic [9:0] quot_q;
  logic       leap_q;
  logic       bad_q;
  logic [8:0] acc_q;
  logic [3:0] idx_q;
  logic       out_valid_q;
  res_t       out_q;

  logic [29:0] prod;
  logic [14:0] rem_full;
  logic [4:0]  rem;
  logic [4:0]  len_idx;
  logic [4:0]  len_prev;
  logic [4:0]  len_in;
  logic [8:0]  year_len;
  logic        ok0;
  logic        ok1;
  logic        done0;
  logic        done1;
  res_t        res;

  // Year over 25 through the reciprocal, then the remainder.
  assign prod     = 30'(item_q.year) * 30'(QuotMul);
  assign rem_full = {1'b0, item_q.year} - (15'(quot_q) * 15'(Divisor25));
  assign rem      = rem_full[4:0];

  // Month lengths used by the range check and by the walk.
  assign len_idx  = month_len(leap_q, idx_q);
  assign len_prev = month_len(leap_q, idx_q - 4'd1);
  assign len_in   = month_len(leap_q, item_q.month_in - 4'd1);
  assign year_len = leap_q ? YearLenLeap : YearLen;

  // Range checks.
  assign ok0 = (item_q.month_in >= MonthFirst) && (item_q.month_in <= MonthLast) &&
               (item_q.day_in != 5'd0) && (item_q.day_in <= len_in);
  assign ok1 = (item_q.year_day_in != 9'd0) && (item_q.year_day_in <= year_len);

  // End of the month walk in each direction.
  assign done0 = (idx_q >= item_q.month_in);
  assign done1 = (idx_q == WalkLast) || (acc_q <= {4'd0, len_idx});

  assign status_o.walk_done = bad_q ||
                              ((item_q.operation == OpToYearDay) ? done0 : done1);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Result fields from the walk registers.
  always_comb begin
    res = '0;
    if (!bad_q) begin
      res.valid_res = 1'b1;
      if (item_q.operation == OpToYearDay) begin
        res.year_day_out = acc_q;
      end else begin
        res.month_out = idx_q + 4'd1;
        res.day_out   = acc_q[4:0];
      end
    end
  end

  // Item, quotient, leap flag and walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.calc_quot) begin
      quot_q <= prod[QuotShift +: 10];
    end
    if (cmd_i.calc_leap) begin
      leap_q <= ((item_q.year[1:0] == 2'd0) && (rem != 5'd0)) ||
                ((item_q.year[3:0] == 4'd0) && (rem == 5'd0));
    end
    if (cmd_i.check) begin
      if (item_q.operation == OpToYearDay) begin
        bad_q <= !ok0;
        acc_q <= {4'd0, item_q.day_in};
        idx_q <= MonthFirst;
      end else begin
        bad_q <= !ok1;
        acc_q <= item_q.year_day_in;
        idx_q <= 4'd0;
      end
    end else if (cmd_i.step) begin
      if (item_q.operation == OpToYearDay) begin
        acc_q <= acc_q + {4'd0, len_prev};
      end else begin
        acc_q <= acc_q - {4'd0, len_idx};
      end
      idx_q <= idx_q + 4'd1;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("loaded result not presented");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && (item_q.operation == OpToMonthDay)) |-> (idx_q < WalkLast))
    else $error("month walk ran past November");

  a_walk_month_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && (item_q.operation == OpToYearDay)) |-> (idx_q < MonthLast))
    else $error("day sum walked past December");

endmodule

// ===== rtl/calendar_date_day_of_year_converter_unit.sv =====
// An accepted input beat passes through the quotient, leap-rule and range-check states,
// then the month walk adds or subtracts one month length a cycle, up to 11 steps;
// the input is stalled until the result is loaded into the output register.
// A finished result waits in an output register while the next item is accepted.
// Reset (rst_ni, asynchronous, active low) clears the controller and the output valid.
module calendar_date_day_of_year_converter_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cdoy_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cdoy_pkg::res_t  out_item_o
);
  import cdoy_pkg::*;

  cmd_t    cmd;
  status_t status;

  cdoy_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cdoy_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
